@@ rtl/core/mtc_pkg.sv @@
// ----------------------------------------------------------------------------
// mtc_pkg: shared types, constants and helpers of the tetrahedra cube block
// Payload structs, register indexes, controller states, the tetrahedron table
// and the fixed-point helpers used by the datapath.
// ----------------------------------------------------------------------------
package mtc_pkg;

	localparam int MAX_POINTS_AXIS_DEF = 256;
	localparam int CORNER_W = 128;
	localparam int CORNER_DEPTH = 8;

	typedef struct packed {
		logic [2:0]         corner;
		logic signed [31:0] density;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic signed [31:0] grad_z;
		logic [7:0]         cell_x;
		logic [7:0]         cell_y;
		logic [7:0]         cell_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vgrad_x;
		logic signed [31:0] vgrad_y;
		logic signed [31:0] vgrad_z;
		logic signed [31:0] face_nx;
		logic signed [31:0] face_ny;
		logic signed [31:0] face_nz;
		logic [55:0]        edge_id;
		logic               last;
	} out_t;

	typedef enum logic [2:0] {
		REG_ISO_LEVEL,
		REG_ISO_EPSILON,
		REG_VOXEL_SIZE,
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_ORIGIN_Z,
		REG_POINTS_X,
		REG_POINTS_Y
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_TET, ST_ERD, ST_EDAT, ST_DIV, ST_M1, ST_M2, ST_M3,
		ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_OUT
	} state_t;

	typedef struct packed {
		logic       wr;
		logic       scan;
		logic [2:0] scan_addr;
		logic       flag_en;
		logic [2:0] flag_idx;
		logic [2:0] tet;
		logic [1:0] eidx;
		logic       div_load;
		logic       div_step;
		logic       m1;
		logic       m2;
		logic       m3;
		logic       t1;
		logic       t2;
		logic       t3;
		logic       t4;
		logic       t5;
		logic       tri_sel;
		logic [1:0] vi;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [2:0] ni;
		logic [5:0] act;
	} status_t;

	function automatic logic [2:0] tet_corner(input logic [2:0] tet, input logic [1:0] i);
		logic [11:0] row;
		case (tet)
			3'd0: row = {3'd7, 3'd3, 3'd1, 3'd0};
			3'd1: row = {3'd7, 3'd5, 3'd1, 3'd0};
			3'd2: row = {3'd7, 3'd3, 3'd2, 3'd0};
			3'd3: row = {3'd7, 3'd6, 3'd2, 3'd0};
			3'd4: row = {3'd7, 3'd5, 3'd4, 3'd0};
			3'd5: row = {3'd7, 3'd6, 3'd4, 3'd0};
			default: row = '0;
		endcase
		return row[3*i +: 3];
	endfunction

	// Returns {from, to}: the edge starts at the lone corner or at an inside corner.
	function automatic logic [5:0] edge_ends(input logic [2:0] tet, input logic [3:0] in_mask,
			input logic [1:0] e);
		logic [2:0] ins [4];
		logic [2:0] outs [4];
		logic [2:0] ni;
		logic [2:0] no;
		logic [2:0] c;
		logic [5:0] r;
		for (int i = 0; i < 4; i++) begin
			ins[i] = '0;
			outs[i] = '0;
		end
		ni = '0;
		no = '0;
		for (int i = 0; i < 4; i++) begin
			c = tet_corner(tet, 2'(i));
			if (in_mask[i]) begin
				ins[ni[1:0]] = c;
				ni = ni + 3'd1;
			end else begin
				outs[no[1:0]] = c;
				no = no + 3'd1;
			end
		end
		if (ni == 3'd2) begin
			case (e)
				2'd0: r = {ins[0], outs[0]};
				2'd1: r = {ins[0], outs[1]};
				2'd2: r = {ins[1], outs[1]};
				default: r = {ins[1], outs[0]};
			endcase
		end else if (ni == 3'd1) begin
			r = {ins[0], outs[e]};
		end else begin
			r = {outs[0], ins[e]};
		end
		return r;
	endfunction

	// (a*b)/2^16 truncated toward zero.
	function automatic logic signed [50:0] mulq16(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic [32:0] ma;
		logic [32:0] mb;
		logic [65:0] p;
		logic [50:0] m;
		ma = a[33] ? 33'(-a) : a[32:0];
		mb = b[33] ? 33'(-b) : b[32:0];
		p = 66'(ma) * 66'(mb);
		m = {1'b0, p[65:16]};
		return (a[33] ^ b[33]) ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		logic signed [31:0] r;
		if (v > 56'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -56'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

@@ rtl/core/mtc_ram.sv @@
// ----------------------------------------------------------------------------
// mtc_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mtc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ rtl/core/mtc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtc_ctrl: sequencer of the tetrahedra cube block
// Walks corner load, inside scan, tetrahedra, edges, triangles and output.
// ----------------------------------------------------------------------------
module mtc_ctrl
	import mtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [2:0] in_corner,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  status_t    status,
	output cmd_t       cmd
);

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [2:0] tet_q, tet_d;
	logic [1:0] eidx_q, eidx_d;
	logic       tri_q, tri_d;
	logic [1:0] vi_q, vi_d;
	logic       two_tri;
	logic [1:0] last_edge;
	logic [5:0] later;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			tet_q <= '0;
			eidx_q <= '0;
			tri_q <= 1'b0;
			vi_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			tet_q <= tet_d;
			eidx_q <= eidx_d;
			tri_q <= tri_d;
			vi_q <= vi_d;
		end
	end

	always_comb begin
		two_tri = (status.ni == 3'd2);
		last_edge = two_tri ? 2'd3 : 2'd2;
		later = status.act >> ({1'b0, tet_q} + 4'd1);

		state_d = state_q;
		cnt_d = cnt_q;
		tet_d = tet_q;
		eidx_d = eidx_q;
		tri_d = tri_q;
		vi_d = vi_q;
		in_ready = 1'b0;
		out_valid = 1'b0;

		cmd = '0;
		cmd.scan_addr = cnt_q[2:0];
		cmd.flag_idx = 3'(cnt_q - 4'd1);
		cmd.tet = tet_q;
		cmd.eidx = eidx_q;
		cmd.tri_sel = tri_q;
		cmd.vi = vi_q;
		cmd.last = (vi_q == 2'd2) && (tri_q == two_tri) && (later == '0);

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.wr = 1'b1;
					if (in_corner == 3'd7) begin
						state_d = ST_SCAN;
						cnt_d = '0;
					end
				end
			end
			ST_SCAN: begin
				// Read data is registered, so it arrives in the cycle after its address.
				cmd.scan = 1'b1;
				cmd.flag_en = (cnt_q != 4'd0);
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd8) begin
					state_d = ST_TET;
					tet_d = '0;
				end
			end
			ST_TET: begin
				if (status.ni == 3'd0 || status.ni == 3'd4) begin
					if (tet_q == 3'd5) state_d = ST_IDLE;
					else tet_d = tet_q + 3'd1;
				end else begin
					eidx_d = '0;
					state_d = ST_ERD;
				end
			end
			ST_ERD: begin
				state_d = ST_EDAT;
			end
			ST_EDAT: begin
				cmd.div_load = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd15) state_d = ST_M1;
			end
			ST_M1: begin
				cmd.m1 = 1'b1;
				state_d = ST_M2;
			end
			ST_M2: begin
				cmd.m2 = 1'b1;
				state_d = ST_M3;
			end
			ST_M3: begin
				cmd.m3 = 1'b1;
				if (eidx_q == last_edge) begin
					tri_d = 1'b0;
					state_d = ST_T1;
				end else begin
					eidx_d = eidx_q + 2'd1;
					state_d = ST_ERD;
				end
			end
			ST_T1: begin
				cmd.t1 = 1'b1;
				state_d = ST_T2;
			end
			ST_T2: begin
				cmd.t2 = 1'b1;
				state_d = ST_T3;
			end
			ST_T3: begin
				cmd.t3 = 1'b1;
				state_d = ST_T4;
			end
			ST_T4: begin
				cmd.t4 = 1'b1;
				state_d = ST_T5;
			end
			ST_T5: begin
				cmd.t5 = 1'b1;
				vi_d = '0;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (vi_q != 2'd2) begin
						vi_d = vi_q + 2'd1;
					end else if (tri_q != two_tri) begin
						tri_d = 1'b1;
						state_d = ST_T1;
					end else if (tet_q == 3'd5) begin
						state_d = ST_IDLE;
					end else begin
						tet_d = tet_q + 3'd1;
						state_d = ST_TET;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/mtc_dp.sv @@
// ----------------------------------------------------------------------------
// mtc_dp: datapath of the tetrahedra cube block
// Corner store, configuration, edge divider, interpolation and face normal.
// ----------------------------------------------------------------------------
module mtc_dp
	import mtc_pkg::*;
#(
	parameter int MAX_POINTS_AXIS = MAX_POINTS_AXIS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  in_t         in_data,
	input  cmd_t        cmd,
	output status_t     status,
	output out_t        out_data
);

	localparam logic [8:0] MAXP = 9'(MAX_POINTS_AXIS);

	logic signed [31:0] iso_q;
	logic [30:0]        eps_q;
	logic [30:0]        vox_q;
	logic signed [31:0] org_q [3];
	logic [8:0]         ptx_q, pty_q;
	logic [23:0]        cell_q;
	logic [7:0]         flags_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q <= '0;
			eps_q <= 31'd7;
			vox_q <= 31'd65536;
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			ptx_q <= 9'd256;
			pty_q <= 9'd256;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_ISO_LEVEL: iso_q <= cfg_data;
				REG_ISO_EPSILON: eps_q <= cfg_data[30:0];
				REG_VOXEL_SIZE: vox_q <= cfg_data[30:0];
				REG_ORIGIN_X: org_q[0] <= cfg_data;
				REG_ORIGIN_Y: org_q[1] <= cfg_data;
				REG_ORIGIN_Z: org_q[2] <= cfg_data;
				REG_POINTS_X: ptx_q <= cfg_data[8:0];
				REG_POINTS_Y: pty_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Density nudge on write.
	logic signed [32:0] wdiff;
	logic [32:0]        wmag;
	logic signed [31:0] dnudge;
	logic [CORNER_W-1:0] wdata;

	always_comb begin
		wdiff = 33'(in_data.density) - 33'(iso_q);
		wmag = wdiff[32] ? 33'(-wdiff) : wdiff;
		if (wmag < {2'b0, eps_q})
			dnudge = sat32(56'(iso_q) + $signed({25'd0, eps_q}));
		else
			dnudge = in_data.density;
		wdata = {in_data.grad_z, in_data.grad_y, in_data.grad_x, dnudge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (cmd.wr) begin
			cell_q <= {in_data.cell_z, in_data.cell_y, in_data.cell_x};
		end
	end

	// Classification against the threshold.
	logic [3:0] ins4;
	logic [3:0] tin;
	logic [5:0] ends;
	logic [2:0] ea, eb;
	logic [2:0] raddr_a;
	logic [CORNER_W-1:0] rdata_a, rdata_b;

	always_comb begin
		for (int i = 0; i < 4; i++) ins4[i] = flags_q[tet_corner(cmd.tet, 2'(i))];
		status.ni = 3'($countones(ins4));
		for (int t = 0; t < 6; t++) begin
			for (int i = 0; i < 4; i++) tin[i] = flags_q[tet_corner(3'(t), 2'(i))];
			status.act[t] = (tin != 4'b0000) && (tin != 4'b1111);
		end
		ends = edge_ends(cmd.tet, ins4, cmd.eidx);
		ea = ends[5:3];
		eb = ends[2:0];
		raddr_a = cmd.scan ? cmd.scan_addr : ea;
	end

	mtc_ram #(
		.WIDTH(CORNER_W),
		.DEPTH(CORNER_DEPTH)
	) u_corner_ram (
		.clk    (clk),
		.we     (cmd.wr),
		.waddr  (in_data.corner),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(eb),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cmd.flag_en) begin
			flags_q[cmd.flag_idx] <= ($signed(rdata_a[31:0]) >= iso_q);
		end
	end

	// Radix-2 divider: t = |iso - da| * 2^16 / |db - da|, t never above 2^16.
	logic signed [32:0] nnum, nden;
	logic [32:0]        un, ud;
	logic [33:0]        rem_q;
	logic [32:0]        den_q;
	logic [16:0]        t_q;
	logic [33:0]        r2;
	logic               ge;

	always_comb begin
		nnum = 33'(iso_q) - 33'($signed(rdata_a[31:0]));
		nden = 33'($signed(rdata_b[31:0])) - 33'($signed(rdata_a[31:0]));
		un = nnum[32] ? 33'(-nnum) : nnum;
		ud = nden[32] ? 33'(-nden) : nden;
		r2 = {rem_q[32:0], 1'b0};
		ge = (r2 >= {1'b0, den_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= (un >= ud) ? {1'b0, un - ud} : {1'b0, un};
			den_q <= ud;
			t_q <= {16'd0, (un >= ud)};
		end else if (cmd.div_step) begin
			rem_q <= ge ? r2 - {1'b0, den_q} : r2;
			t_q <= {t_q[15:0], ge};
		end
	end

	// Vertex interpolation and edge key.
	logic [8:0]         pxc, pyc;
	logic [8:0]         ca [3];
	logic [8:0]         cb [3];
	logic signed [31:0] ga [3];
	logic signed [31:0] gb [3];
	logic signed [50:0] gm_q [3];
	logic [31:0]        vt_q;
	logic [39:0]        cpa_q [3];
	logic [17:0]        zpa_q, zpb_q;
	logic signed [31:0] vpos_q [3];
	logic signed [31:0] vgr_q [3];
	logic [26:0]        ia_q, ib_q;
	logic signed [55:0] psum [3];
	logic signed [55:0] dterm [3];
	logic signed [50:0] vtm;
	logic [26:0]        ida, idb, ismall, ilarge;

	always_comb begin
		pxc = (ptx_q > MAXP) ? MAXP : ptx_q;
		pyc = (pty_q > MAXP) ? MAXP : pty_q;
		for (int k = 0; k < 3; k++) begin
			ca[k] = {1'b0, cell_q[8*k +: 8]} + 9'(ea[k]);
			cb[k] = {1'b0, cell_q[8*k +: 8]} + 9'(eb[k]);
			ga[k] = rdata_a[32*k+32 +: 32];
			gb[k] = rdata_b[32*k+32 +: 32];
			if (eb[k] && !ea[k]) dterm[k] = $signed({24'd0, vt_q});
			else if (ea[k] && !eb[k]) dterm[k] = -$signed({24'd0, vt_q});
			else dterm[k] = '0;
			psum[k] = 56'(org_q[k]) + $signed({16'd0, cpa_q[k]}) + dterm[k];
		end
		vtm = mulq16($signed({3'd0, vox_q}), $signed({17'd0, t_q}));
		ida = ia_q + 27'(ca[0]);
		idb = ib_q + 27'(cb[0]);
		ismall = (ida < idb) ? ida : idb;
		ilarge = (ida < idb) ? idb : ida;
	end

	always_ff @(posedge clk) begin
		if (cmd.m1) begin
			for (int k = 0; k < 3; k++) begin
				gm_q[k] <= mulq16(34'(gb[k]) - 34'(ga[k]), $signed({17'd0, t_q}));
				cpa_q[k] <= 40'(ca[k]) * 40'(vox_q);
			end
			vt_q <= vtm[31:0];
			zpa_q <= 18'(ca[2]) * 18'(pyc);
			zpb_q <= 18'(cb[2]) * 18'(pyc);
		end
		if (cmd.m2) begin
			for (int k = 0; k < 3; k++) begin
				vpos_q[k] <= sat32(psum[k]);
				vgr_q[k] <= sat32(56'(ga[k]) + 56'(gm_q[k]));
			end
			ia_q <= 27'(zpa_q + 18'(ca[1])) * 27'(pxc);
			ib_q <= 27'(zpb_q + 18'(cb[1])) * 27'(pxc);
		end
	end

	// Edge vertices of the current tetrahedron.
	logic signed [31:0] sp_q [4][3];
	logic signed [31:0] sg_q [4][3];
	logic [55:0]        sk_q [4];

	always_ff @(posedge clk) begin
		if (cmd.m3) begin
			for (int k = 0; k < 3; k++) begin
				sp_q[cmd.eidx][k] <= vpos_q[k];
				sg_q[cmd.eidx][k] <= vgr_q[k];
			end
			sk_q[cmd.eidx] <= {ismall[23:0], 5'd0, ilarge};
		end
	end

	// Face normal of triangle A, B, C. The second triangle of a split keeps A and
	// takes B and C from the edge vertices that follow the ones they replace.
	logic signed [31:0] pa [3];
	logic signed [31:0] pb [3];
	logic signed [31:0] pc [3];
	logic signed [31:0] gva [3];
	logic signed [31:0] gvb [3];
	logic signed [31:0] gvc [3];
	logic signed [32:0] e1_q [3];
	logic signed [32:0] e2_q [3];
	logic signed [33:0] gs_q [3];
	logic signed [50:0] pr_q [6];
	logic signed [31:0] n_q [3];
	logic signed [50:0] dp_q [3];
	logic signed [31:0] nf_q [3];
	logic signed [52:0] dot;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pa[k] = sp_q[0][k];
			pb[k] = cmd.tri_sel ? sp_q[2][k] : sp_q[1][k];
			pc[k] = cmd.tri_sel ? sp_q[3][k] : sp_q[2][k];
			gva[k] = sg_q[0][k];
			gvb[k] = cmd.tri_sel ? sg_q[2][k] : sg_q[1][k];
			gvc[k] = cmd.tri_sel ? sg_q[3][k] : sg_q[2][k];
		end
		dot = 53'(dp_q[0]) + 53'(dp_q[1]) + 53'(dp_q[2]);
	end

	always_ff @(posedge clk) begin
		if (cmd.t1) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= 33'(pb[k]) - 33'(pa[k]);
				e2_q[k] <= 33'(pc[k]) - 33'(pa[k]);
				gs_q[k] <= 34'(gva[k]) + 34'(gvb[k]) + 34'(gvc[k]);
			end
		end
		if (cmd.t2) begin
			pr_q[0] <= mulq16(34'(e1_q[1]), 34'(e2_q[2]));
			pr_q[1] <= mulq16(34'(e1_q[2]), 34'(e2_q[1]));
			pr_q[2] <= mulq16(34'(e1_q[2]), 34'(e2_q[0]));
			pr_q[3] <= mulq16(34'(e1_q[0]), 34'(e2_q[2]));
			pr_q[4] <= mulq16(34'(e1_q[0]), 34'(e2_q[1]));
			pr_q[5] <= mulq16(34'(e1_q[1]), 34'(e2_q[0]));
		end
		if (cmd.t3) begin
			for (int k = 0; k < 3; k++) n_q[k] <= sat32(56'(pr_q[2*k]) - 56'(pr_q[2*k+1]));
		end
		if (cmd.t4) begin
			for (int k = 0; k < 3; k++) dp_q[k] <= mulq16(34'(n_q[k]), gs_q[k]);
		end
		if (cmd.t5) begin
			for (int k = 0; k < 3; k++) nf_q[k] <= dot[52] ? sat32(-56'(n_q[k])) : n_q[k];
		end
	end

	// Result selection.
	logic signed [31:0] op [3];
	logic signed [31:0] og [3];
	logic [55:0]        okey;

	always_comb begin
		case (cmd.vi)
			2'd0: begin
				op = pa;
				og = gva;
				okey = sk_q[0];
			end
			2'd1: begin
				op = pb;
				og = gvb;
				okey = cmd.tri_sel ? sk_q[2] : sk_q[1];
			end
			default: begin
				op = pc;
				og = gvc;
				okey = cmd.tri_sel ? sk_q[3] : sk_q[2];
			end
		endcase
		out_data.pos_x = op[0];
		out_data.pos_y = op[1];
		out_data.pos_z = op[2];
		out_data.vgrad_x = og[0];
		out_data.vgrad_y = og[1];
		out_data.vgrad_z = og[2];
		out_data.face_nx = nf_q[0];
		out_data.face_ny = nf_q[1];
		out_data.face_nz = nf_q[2];
		out_data.edge_id = okey;
		out_data.last = cmd.last;
	end

endmodule

@@ rtl/core/marching_tetrahedra_cube.sv @@
// ----------------------------------------------------------------------------
// marching_tetrahedra_cube: six-tetrahedra cube polygonizer, Q16.16
// Takes eight corner samples per cube and emits interpolated triangle vertices.
// ----------------------------------------------------------------------------
// Corners 0 to 6 are taken one a cycle while the block is idle. Corner 7 starts
// the cube: a scan classifies the corners, then each of the six tetrahedra is
// checked, each crossing edge goes through read, divider load, 16 steps of the
// radix-2 divider for the interpolation fraction and three arithmetic steps, and
// each triangle through five steps for its normal and then its three results,
// which wait while results are stalled. The shared divider works the edges one
// after another. No input is taken until the cube is done, so not before its last
// vertex is delivered.
// ----------------------------------------------------------------------------
module marching_tetrahedra_cube
	import mtc_pkg::*;
#(
	parameter int MAX_POINTS_AXIS = MAX_POINTS_AXIS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	cmd_t    cmd;
	status_t status;

	mtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_corner(in_data.corner),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mtc_dp #(
		.MAX_POINTS_AXIS(MAX_POINTS_AXIS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the tetrahedra cube polygonizer
// Streams corner samples through the request channel and checks every triangle
// vertex against an in-bench prediction, over several register settings.
// ----------------------------------------------------------------------------
module tb_top;
	import mtc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;

	marching_tetrahedra_cube dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register shadows and corner store of the prediction.
	longint iso_lvl = 0, iso_eps = 7, vox = 65536;
	longint org [3] = '{0, 0, 0};
	longint pts_x = 256, pts_y = 256;
	longint dens [8];
	longint grad [8][3];
	longint cur_cell [3];
	longint cube_pos [8][3];
	longint unsigned pt_index [8];
	int tet_map [6][4] = '{'{0,1,3,7}, '{0,1,5,7}, '{0,2,3,7},
		'{0,2,6,7}, '{0,4,5,7}, '{0,4,6,7}};

	in_t  corner_queue [$];
	out_t vertex_queue [$];
	int   mismatches = 0;
	bit   idling = 1'b1;
	int   send_gap = 0;
	int   stall_len = 0;
	int   quiet_cycles = 0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned mag64(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	// Product scaled by 2^-16, truncated toward zero, kept exact in 128 bits.
	function automatic longint mul_frac(longint a, longint b);
		logic [127:0] p;
		p = 128'(mag64(a)) * 128'(mag64(b));
		p = p >> 16;
		return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idling || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_vertex(out_t v);
		vertex_queue = {vertex_queue, v};
	endtask

	task automatic add_corner(in_t it);
		corner_queue = {corner_queue, it};
	endtask

	function automatic out_t edge_vertex(int a, int b);
		longint t;
		longint unsigned un, ud;
		out_t v;
		un = mag64(iso_lvl - dens[a]);
		ud = mag64(dens[b] - dens[a]);
		t = (ud != 0) ? longint'((un << 16) / ud) : 0;
		v = '0;
		v.pos_x = 32'(clamp32(cube_pos[a][0] + mul_frac(cube_pos[b][0] - cube_pos[a][0], t)));
		v.pos_y = 32'(clamp32(cube_pos[a][1] + mul_frac(cube_pos[b][1] - cube_pos[a][1], t)));
		v.pos_z = 32'(clamp32(cube_pos[a][2] + mul_frac(cube_pos[b][2] - cube_pos[a][2], t)));
		v.vgrad_x = 32'(clamp32(grad[a][0] + mul_frac(grad[b][0] - grad[a][0], t)));
		v.vgrad_y = 32'(clamp32(grad[a][1] + mul_frac(grad[b][1] - grad[a][1], t)));
		v.vgrad_z = 32'(clamp32(grad[a][2] + mul_frac(grad[b][2] - grad[a][2], t)));
		if (pt_index[a] < pt_index[b])
			v.edge_id = 56'((pt_index[a] << 32) | pt_index[b]);
		else
			v.edge_id = 56'((pt_index[b] << 32) | pt_index[a]);
		return v;
	endfunction

	task automatic push_triangle(out_t a, out_t b, out_t c);
		longint e1 [3], e2 [3], gs [3], n [3];
		longint dot;
		e1[0] = longint'(b.pos_x) - longint'(a.pos_x);
		e1[1] = longint'(b.pos_y) - longint'(a.pos_y);
		e1[2] = longint'(b.pos_z) - longint'(a.pos_z);
		e2[0] = longint'(c.pos_x) - longint'(a.pos_x);
		e2[1] = longint'(c.pos_y) - longint'(a.pos_y);
		e2[2] = longint'(c.pos_z) - longint'(a.pos_z);
		gs[0] = longint'(a.vgrad_x) + longint'(b.vgrad_x) + longint'(c.vgrad_x);
		gs[1] = longint'(a.vgrad_y) + longint'(b.vgrad_y) + longint'(c.vgrad_y);
		gs[2] = longint'(a.vgrad_z) + longint'(b.vgrad_z) + longint'(c.vgrad_z);
		n[0] = clamp32(mul_frac(e1[1], e2[2]) - mul_frac(e1[2], e2[1]));
		n[1] = clamp32(mul_frac(e1[2], e2[0]) - mul_frac(e1[0], e2[2]));
		n[2] = clamp32(mul_frac(e1[0], e2[1]) - mul_frac(e1[1], e2[0]));
		dot = mul_frac(n[0], gs[0]) + mul_frac(n[1], gs[1]) + mul_frac(n[2], gs[2]);
		// The normal is flipped to face along the summed gradients.
		if (dot < 0)
			for (int k = 0; k < 3; k++) n[k] = clamp32(-n[k]);
		a.face_nx = 32'(n[0]); a.face_ny = 32'(n[1]); a.face_nz = 32'(n[2]);
		b.face_nx = 32'(n[0]); b.face_ny = 32'(n[1]); b.face_nz = 32'(n[2]);
		c.face_nx = 32'(n[0]); c.face_ny = 32'(n[1]); c.face_nz = 32'(n[2]);
		add_vertex(a);
		add_vertex(b);
		add_vertex(c);
	endtask

	task automatic predict_vertices(in_t it);
		longint d, px, py, x, y, z;
		int ins [4], outs [4];
		int ni, no, cc, apex, added;
		d = longint'(it.density);
		if (mag64(d - iso_lvl) < iso_eps) d = clamp32(iso_lvl + iso_eps);
		dens[it.corner] = d;
		grad[it.corner][0] = longint'(it.grad_x);
		grad[it.corner][1] = longint'(it.grad_y);
		grad[it.corner][2] = longint'(it.grad_z);
		cur_cell[0] = longint'(it.cell_x);
		cur_cell[1] = longint'(it.cell_y);
		cur_cell[2] = longint'(it.cell_z);
		if (it.corner != 3'd7) return;
		px = pts_x > 256 ? 256 : pts_x;
		py = pts_y > 256 ? 256 : pts_y;
		for (int i = 0; i < 8; i++) begin
			x = cur_cell[0] + (i & 1);
			y = cur_cell[1] + ((i >> 1) & 1);
			z = cur_cell[2] + ((i >> 2) & 1);
			cube_pos[i][0] = org[0] + x * vox;
			cube_pos[i][1] = org[1] + y * vox;
			cube_pos[i][2] = org[2] + z * vox;
			pt_index[i] = (z * py + y) * px + x;
		end
		added = vertex_queue.size();
		for (int t = 0; t < 6; t++) begin
			ni = 0;
			no = 0;
			for (int i = 0; i < 4; i++) begin
				cc = tet_map[t][i];
				if (dens[cc] >= iso_lvl) begin
					ins[ni] = cc; ni++;
				end else begin
					outs[no] = cc; no++;
				end
			end
			if (ni == 0 || no == 0) continue;
			if (ni == 1) begin
				apex = ins[0];
				push_triangle(edge_vertex(apex, outs[0]), edge_vertex(apex, outs[1]),
					edge_vertex(apex, outs[2]));
			end else if (no == 1) begin
				apex = outs[0];
				push_triangle(edge_vertex(apex, ins[0]), edge_vertex(apex, ins[1]),
					edge_vertex(apex, ins[2]));
			end else begin
				push_triangle(edge_vertex(ins[0], outs[0]), edge_vertex(ins[0], outs[1]),
					edge_vertex(ins[1], outs[1]));
				push_triangle(edge_vertex(ins[0], outs[0]), edge_vertex(ins[1], outs[1]),
					edge_vertex(ins[1], outs[0]));
			end
		end
		if (vertex_queue.size() > added) vertex_queue[vertex_queue.size() - 1].last = 1'b1;
	endtask

	task automatic check_vertex(out_t w, out_t g);
		bit bad;
		bad = 1'b0;
		if (g.pos_x !== w.pos_x) begin $error("pos_x exp %0d got %0d", w.pos_x, g.pos_x); bad = 1; end
		if (g.pos_y !== w.pos_y) begin $error("pos_y exp %0d got %0d", w.pos_y, g.pos_y); bad = 1; end
		if (g.pos_z !== w.pos_z) begin $error("pos_z exp %0d got %0d", w.pos_z, g.pos_z); bad = 1; end
		if (g.vgrad_x !== w.vgrad_x) begin
			$error("vgrad_x exp %0d got %0d", w.vgrad_x, g.vgrad_x); bad = 1;
		end
		if (g.vgrad_y !== w.vgrad_y) begin
			$error("vgrad_y exp %0d got %0d", w.vgrad_y, g.vgrad_y); bad = 1;
		end
		if (g.vgrad_z !== w.vgrad_z) begin
			$error("vgrad_z exp %0d got %0d", w.vgrad_z, g.vgrad_z); bad = 1;
		end
		if (g.face_nx !== w.face_nx) begin
			$error("face_nx exp %0d got %0d", w.face_nx, g.face_nx); bad = 1;
		end
		if (g.face_ny !== w.face_ny) begin
			$error("face_ny exp %0d got %0d", w.face_ny, g.face_ny); bad = 1;
		end
		if (g.face_nz !== w.face_nz) begin
			$error("face_nz exp %0d got %0d", w.face_nz, g.face_nz); bad = 1;
		end
		if (g.edge_id !== w.edge_id) begin
			$error("edge_id exp %h got %h", w.edge_id, g.edge_id); bad = 1;
		end
		if (g.last !== w.last) begin $error("last exp %0d got %0d", w.last, g.last); bad = 1; end
		if (bad) mismatches++;
	endtask

	// Request driver: one request at a time from the pending queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) predict_vertices(in_data);
			if (in_valid && !in_ready) begin
				// Hold the request until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (corner_queue.size() > 0) begin
				in_data <= corner_queue.pop_front();
				in_valid <= 1'b1;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_len = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (vertex_queue.size() == 0) begin
					$error("vertex delivered with none expected");
					mismatches++;
				end else begin
					check_vertex(vertex_queue.pop_front(), out_data);
				end
			end
			if (stall_len > 0) begin
				stall_len--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_len = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		case (r)
			REG_ISO_LEVEL:   iso_lvl = longint'($signed(v));
			REG_ISO_EPSILON: iso_eps = longint'(v[30:0]);
			REG_VOXEL_SIZE:  vox = longint'(v[30:0]);
			REG_ORIGIN_X:    org[0] = longint'($signed(v));
			REG_ORIGIN_Y:    org[1] = longint'($signed(v));
			REG_ORIGIN_Z:    org[2] = longint'($signed(v));
			REG_POINTS_X:    pts_x = longint'(v[8:0]);
			REG_POINTS_Y:    pts_y = longint'(v[8:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic write_all(logic [31:0] lv, logic [31:0] ep, logic [31:0] vs,
			logic [31:0] ox, logic [31:0] oy, logic [31:0] oz, logic [31:0] nx,
			logic [31:0] ny);
		write_reg(REG_ISO_LEVEL, lv);
		write_reg(REG_ISO_EPSILON, ep);
		write_reg(REG_VOXEL_SIZE, vs);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_POINTS_X, nx);
		write_reg(REG_POINTS_Y, ny);
	endtask

	// Sampled on the falling edge so the driver's updates have settled. A last
	// cube without any crossing gives no results, so the task waits on after the queues drain to cover it.
	task automatic wait_idle();
		@(negedge clk);
		while (corner_queue.size() > 0 || in_valid || vertex_queue.size() > 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic in_t make_item(int c, longint d, longint gx, longint gy, longint gz,
			int x, int y, int z);
		in_t it;
		it.corner = 3'(c);
		it.density = 32'(d);
		it.grad_x = 32'(gx);
		it.grad_y = 32'(gy);
		it.grad_z = 32'(gz);
		it.cell_x = 8'(x);
		it.cell_y = 8'(y);
		it.cell_z = 8'(z);
		return it;
	endfunction

	function automatic longint rand_density();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return clamp32(iso_lvl + longint'($urandom_range(0, 1 << 19)) - (1 << 18));
		if (r < 8) return clamp32(iso_lvl + longint'($urandom_range(0, 6)) - 3);
		return longint'($signed($urandom));
	endfunction

	function automatic longint rand_grad();
		if ($urandom_range(0, 9) < 8)
			return longint'($urandom_range(0, 1 << 21)) - (1 << 20);
		return longint'($signed($urandom));
	endfunction

	task automatic queue_random_cube(inout int sent);
		int ord [7];
		int j, tmp, x, y, z;
		x = $urandom_range(0, 254);
		y = $urandom_range(0, 254);
		z = $urandom_range(0, 254);
		for (int k = 0; k < 7; k++) ord[k] = k;
		for (int k = 6; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = ord[k]; ord[k] = ord[j]; ord[j] = tmp;
		end
		for (int k = 0; k < 7; k++)
			add_corner(make_item(ord[k], rand_density(), rand_grad(),
				rand_grad(), rand_grad(), x, y, z));
		add_corner(make_item(7, rand_density(), rand_grad(), rand_grad(),
			rand_grad(), x, y, z));
		sent += 8;
	endtask

	// Broken sequences: stray corners in any order with fully random content.
	task automatic queue_noise(inout int sent);
		int n;
		n = $urandom_range(1, 4);
		for (int k = 0; k < n; k++)
			add_corner(make_item($urandom_range(0, 7), longint'($signed($urandom)),
				longint'($signed($urandom)), longint'($signed($urandom)),
				longint'($signed($urandom)), $urandom_range(0, 254), $urandom_range(0, 254),
				$urandom_range(0, 254)));
		sent += n;
	endtask

	task automatic random_phase(int target);
		int sent;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(0, 9) < 8) queue_random_cube(sent);
			else queue_noise(sent);
		end
		wait_idle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_all(32'd0, 32'd7, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd256, 32'd256);

		// One corner inside: every tetrahedron splits one against three.
		for (int c = 0; c < 8; c++)
			add_corner(make_item(c, c == 0 ? 65536 : -65536, 32'sh7FFFFFFF,
				-64'sd2147483648, c * 4096, 0, 0, 0));
		// Alternating corners: two against two splits among others, density extremes, far cell.
		for (int c = 0; c < 8; c++)
			add_corner(make_item(c, (c & 1) ? 64'sd2147483647 : -64'sd2147483648,
				-c * 70000, c * 9000, 32'sh7FFFFFFF, 254, 254, 254));
		// Densities on the threshold are nudged inside: no crossing, no results.
		for (int c = 0; c < 8; c++)
			add_corner(make_item(c, 0, -64'sd2147483648, 32'sh7FFFFFFF, 0,
				c * 30, 254 - c, 17));
		wait_idle();

		write_all(32'hFFFF0000 + $urandom_range(0, 1 << 17), $urandom_range(0, 1 << 16),
			$urandom_range(1, 1 << 20), $urandom, $urandom, $urandom,
			$urandom_range(2, 256), $urandom_range(2, 256));
		random_phase(20);

		// Extremes: the nudge saturates at the top of the range.
		write_all(32'h7FFFFFF0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'd511, 32'd2);
		for (int c = 0; c < 8; c++)
			add_corner(make_item(c, (c == 3) ? -64'sd2147483648 : 32'sh7FFFFFFF,
				c * 3, -c, 7, 254, 0, 254));
		wait_idle();
		idling = 1'b0;
		random_phase(12);
		idling = 1'b1;

		write_all(32'h80000000, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
		random_phase(12);
		write_all($urandom_range(0, 1 << 18) - (1 << 17), 32'd3, 32'd65536, 32'd0, 32'd0,
			32'd0, 32'd256, 32'd257);
		random_phase(12);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/mtc_pkg.sv
rtl/core/mtc_ram.sv
rtl/core/mtc_ctrl.sv
rtl/core/mtc_dp.sv
rtl/core/marching_tetrahedra_cube.sv
tb/tb_top.sv
